// File: rtl/itaw_pkg.sv
package itaw_pkg;

  localparam int ADDR_BITS = 48;
  localparam int LINE_BYTES = 64;
  localparam int LINE_SHIFT = $clog2(LINE_BYTES);
  localparam int MAC_BYTES = 8;
  localparam int MAX_LEVELS_DEFAULT = 8;
  localparam int ENTRY_BITS = 42;
  localparam int LINES_BITS = 43;
  localparam int LEVEL_BITS = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 48;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  localparam logic [1:0] KIND_MAC = 2'd0;
  localparam logic [1:0] KIND_CTR = 2'd1;
  localparam logic [1:0] KIND_TREE = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINES = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CTR_SHIFT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEAF_SHIFT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TREE_SHIFT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OOP = 3'd5;

  typedef struct packed {
    logic busy;
    logic oop;
    addr_t region_base;
    addr_t mac_start;
    logic [LEVEL_BITS-1:0] level_count;
    logic signed [2:0] ctr_shift;
    logic signed [2:0] tree_shift;
    logic [3:0] leaf_shift;
    logic [3:0] arity_shift;
  } layout_t;

  // power-of-two scaling; right shift floors
  function automatic addr_t scale(input addr_t x, input logic signed [3:0] s);
    logic [3:0] mag;
    mag = s[3] ? 4'(-s) : 4'(s);
    return s[3] ? (x >> mag) : (x << mag);
  endfunction

endpackage

// File: rtl/itaw_layout.sv
module itaw_layout import itaw_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output layout_t                   lay,
  output addr_t [MAX_LEVELS:0]      level_start
);

  localparam int IDX_BITS = $clog2(MAX_LEVELS + 1);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_INIT = 3'd1;
  localparam logic [2:0] L_LOOP = 3'd2;
  localparam logic [2:0] L_ROOT = 3'd3;
  localparam logic [2:0] L_BASE = 3'd4;
  localparam logic [2:0] L_FILL = 3'd5;

  logic [2:0] state;
  addr_t region_base;
  logic [LINES_BITS-1:0] region_lines;
  logic signed [2:0] ctr_shift, tree_shift;
  logic [3:0] leaf_shift;
  logic oop;

  addr_t s, total, leaf, macs, ctrs, mac_start, ctr_start, tree, roots_bytes, sz, prev;
  logic [LEVEL_BITS-1:0] n, idx;

  addr_t lines_w, ctrs_v, s_next, mem;
  logic signed [3:0] c4, t4, neg_t4;
  logic [3:0] arity_shift;

  always_comb begin
    lines_w = addr_t'(region_lines);
    mem = lines_w << LINE_SHIFT;
    c4 = {ctr_shift[2], ctr_shift};
    t4 = {tree_shift[2], tree_shift};
    neg_t4 = 4'(-t4);
    ctrs_v = oop ? '0 : scale(lines_w, c4);
    s_next = scale(s >> LINE_SHIFT, t4);
    arity_shift = 4'(LINE_SHIFT - int'(t4));
  end

  assign lay.busy = (state != L_IDLE);
  assign lay.oop = oop;
  assign lay.region_base = region_base;
  assign lay.mac_start = mac_start;
  assign lay.level_count = n;
  assign lay.ctr_shift = ctr_shift;
  assign lay.tree_shift = tree_shift;
  assign lay.leaf_shift = leaf_shift;
  assign lay.arity_shift = arity_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_lines <= '0;
      ctr_shift <= '0;
      leaf_shift <= 4'd6;
      tree_shift <= '0;
      oop <= 1'b0;
      n <= '0;
      state <= L_INIT;
    end else if (cfg_we && cfg_index <= REG_OOP) begin
      unique case (cfg_index)
        REG_BASE:       region_base <= cfg_data[ADDR_BITS-1:0];
        REG_LINES:      region_lines <= cfg_data[LINES_BITS-1:0];
        REG_CTR_SHIFT:  ctr_shift <= cfg_data[2:0];
        REG_LEAF_SHIFT: leaf_shift <= cfg_data[3:0];
        REG_TREE_SHIFT: tree_shift <= cfg_data[2:0];
        default:        oop <= cfg_data[0];
      endcase
      state <= L_INIT;
    end else begin
      unique case (state)
        L_INIT: begin
          macs <= lines_w * addr_t'(MAC_BYTES);
          ctrs <= ctrs_v;
          s <= ctrs_v;
          leaf <= scale(ctrs_v >> LINE_SHIFT, t4);
          total <= '0;
          n <= '0;
          state <= L_LOOP;
        end
        L_LOOP: begin
          if (s > addr_t'(LINE_BYTES) && n < LEVEL_BITS'(MAX_LEVELS)) begin
            s <= s_next;
            total <= total + s_next;
            n <= n + 1'b1;
          end else begin
            state <= L_ROOT;
          end
        end
        L_ROOT: begin
          mac_start <= region_base + mem - macs;
          ctr_start <= region_base + mem - macs - ctrs;
          tree <= ((leaf << 1) > total) ? (leaf << 1) : total;
          roots_bytes <= scale(s, neg_t4) << LINE_SHIFT;
          state <= L_BASE;
        end
        L_BASE: begin
          prev <= ctr_start - tree;
          level_start[0] <= ctr_start - tree;
          sz <= addr_t'(LINE_BYTES);
          idx <= LEVEL_BITS'(1);
          state <= L_FILL;
        end
        L_FILL: begin
          if (idx < n) begin
            level_start[idx[IDX_BITS-1:0]] <= prev + sz;
            prev <= prev + sz;
            // level 1 holds the roots, deeper levels grow by the arity
            sz <= (idx == LEVEL_BITS'(1)) ? roots_bytes : (sz << arity_shift);
            idx <= idx + 1'b1;
          end else begin
            level_start[n[IDX_BITS-1:0]] <= ctr_start;
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  a_fill_idx: assert property (@(posedge clk) disable iff (rst)
    (state == L_FILL) |-> (idx != 0 && n <= LEVEL_BITS'(MAX_LEVELS)))
    else $error("layout fill index out of range");
  a_loop_cap: assert property (@(posedge clk) disable iff (rst)
    (state == L_LOOP) |=> (n <= LEVEL_BITS'(MAX_LEVELS)))
    else $error("level count exceeds limit");
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index <= REG_OOP) |=> (state == L_INIT))
    else $error("config write did not restart layout");

endmodule

// File: rtl/itaw_front.sv
module itaw_front import itaw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  addr_t   data_address,
  input  layout_t lay,
  input  logic    pop,
  output logic    q_valid,
  output entry_t  q_entry
);

  localparam int DEPTH = 2;

  entry_t entries [DEPTH];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push;
  entry_t line_num;

  assign line_num = entry_t'((data_address - lay.region_base) >> LINE_SHIFT);
  assign in_ready = (count != 2'(DEPTH)) && !lay.busy;
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= line_num;
        wr_ptr <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH)) else $error("queue overflow");
  a_push: assert property (@(posedge clk) disable iff (rst)
    push |=> (count != 2'd0)) else $error("pushed item lost");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("pop from empty queue");

endmodule

// File: rtl/itaw_back.sv
module itaw_back import itaw_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  layout_t               lay,
  input  addr_t [MAX_LEVELS:0]  level_start,
  input  logic                  q_valid,
  input  entry_t                q_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [LEVEL_BITS-1:0] tree_level,
  output entry_t                entry_number,
  output addr_t                 meta_address,
  output logic                  last
);

  localparam int IDX_BITS = $clog2(MAX_LEVELS + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_CTR = 2'd1;
  localparam logic [1:0] P_TREE = 2'd2;

  logic [1:0] phase;
  entry_t walk_entry;
  logic [LEVEL_BITS-1:0] walk_level;

  logic load;
  addr_t mac_addr, ctr_addr, tree_addr;
  entry_t step_entry;
  logic [LEVEL_BITS-1:0] step_level;

  always_comb begin
    load = !out_valid || out_ready;
    mac_addr = lay.mac_start + addr_t'(q_entry) * addr_t'(MAC_BYTES);
    ctr_addr = level_start[lay.level_count[IDX_BITS-1:0]]
             + scale(addr_t'(walk_entry), {lay.ctr_shift[2], lay.ctr_shift});
    // leaf entries cover a configured counter count, inner nodes the arity
    step_entry = (walk_level == lay.level_count) ? (walk_entry >> lay.leaf_shift)
                                                 : (walk_entry >> lay.arity_shift);
    step_level = walk_level - 1'b1;
    tree_addr = level_start[step_level[IDX_BITS-1:0]]
              + scale(addr_t'(step_entry), {lay.tree_shift[2], lay.tree_shift});
    pop = load && (phase == P_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (q_valid) begin
            out_valid <= 1'b1;
            kind <= KIND_MAC;
            tree_level <= '0;
            entry_number <= q_entry;
            meta_address <= mac_addr;
            last <= lay.oop;
            walk_entry <= q_entry;
            walk_level <= lay.level_count;
            if (!lay.oop) phase <= P_CTR;
          end
        end
        P_CTR: begin
          out_valid <= 1'b1;
          kind <= KIND_CTR;
          tree_level <= walk_level;
          entry_number <= walk_entry;
          meta_address <= ctr_addr;
          last <= (walk_level == '0);
          phase <= (walk_level == '0) ? P_IDLE : P_TREE;
        end
        P_TREE: begin
          out_valid <= 1'b1;
          kind <= KIND_TREE;
          tree_level <= step_level;
          entry_number <= step_entry;
          meta_address <= tree_addr;
          last <= (step_level == '0);
          walk_entry <= step_entry;
          walk_level <= step_level;
          if (step_level == '0) phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  a_tree_level: assert property (@(posedge clk) disable iff (rst)
    (phase == P_TREE) |-> (walk_level != '0)) else $error("tree step below root");
  a_pop_mac: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && kind == KIND_MAC)) else $error("item did not start with MAC");
  a_ctr_level: assert property (@(posedge clk) disable iff (rst)
    (phase == P_CTR) |-> (walk_level == lay.level_count))
    else $error("counter step at wrong level");

endmodule

// File: rtl/integrity_tree_address_walk.sv
// The first result (the MAC address) passes through the queue and the output register.
// The walk unit gives one result per cycle while out_ready is high; an item gives
// 2 + level_count results (up to MAX_LEVELS + 2), or one in out-of-place mode, and the
// next item leaves the 2-entry queue after the last. Reset and each write to REG_BASE
// to REG_OOP start a layout pass, with in_ready low; registers reset to their defaults.
module integrity_tree_address_walk import itaw_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  addr_t                     data_address,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic [LEVEL_BITS-1:0]     tree_level,
  output entry_t                    entry_number,
  output addr_t                     meta_address,
  output logic                      last
);

  layout_t lay;
  addr_t [MAX_LEVELS:0] level_start;
  logic pop, q_valid;
  entry_t q_entry;

  itaw_layout #(.MAX_LEVELS(MAX_LEVELS)) u_layout (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .lay, .level_start
  );

  itaw_front u_front (
    .clk, .rst, .in_valid, .in_ready, .data_address, .lay, .pop, .q_valid, .q_entry
  );

  itaw_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk, .rst, .lay, .level_start, .q_valid, .q_entry, .pop,
    .out_valid, .out_ready, .kind, .tree_level, .entry_number, .meta_address, .last
  );

endmodule

// File: tb/sv/tb_integrity_tree_address_walk.sv
`timescale 1ns / 100ps

module tb_integrity_tree_address_walk;
  import itaw_pkg::*;

  localparam int MAXLV = MAX_LEVELS_DEFAULT;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] level;
    entry_t     entry;
    addr_t      addr;
    logic       last;
  } meta_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  addr_t data_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [LEVEL_BITS-1:0] tree_level;
  entry_t entry_number;
  addr_t meta_address;
  logic last;

  integrity_tree_address_walk dut (.*);

  always #2 clk = ~clk;

  // layout copy
  logic [47:0] base_r;
  logic [42:0] lines_r;
  int ctr_sh, tree_sh;
  int unsigned leaf_sh;
  bit oop_r;
  logic [63:0] lvl_start [0:MAXLV];
  int unsigned nlev;
  logic [63:0] mac_base, arity_v;

  addr_t pending_addrs[$];
  meta_rec_t expected_meta[$];
  int errors = 0;
  bit quiet_phase = 0;
  bit hold_sink = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] pow2_scale(logic [63:0] x, int s);
    return (s >= 0) ? (x << s) : (x >> (-s));
  endfunction

  function automatic void compute_layout();
    logic [63:0] am, mem, macs, ctrs, s, total, leafsz, treesz, roots, sz, cstart;
    int unsigned n;
    am = (64'd1 << 48) - 1;
    mem = lines_r * 64'd64;
    macs = lines_r * 64'd8;
    ctrs = oop_r ? 64'd0 : pow2_scale(lines_r, ctr_sh);
    s = ctrs; total = 0; treesz = 0; roots = 0; n = 0;
    if (!oop_r) begin
      while (s > 64 && n < MAXLV) begin
        s = pow2_scale(s / 64, tree_sh);
        n++;
        total += s;
      end
      leafsz = pow2_scale(ctrs / 64, tree_sh);
      treesz = (leafsz * 2 > total) ? leafsz * 2 : total;
      roots = pow2_scale(s, -tree_sh);
    end
    arity_v = pow2_scale(64'd64, -tree_sh);
    if (arity_v == 0) arity_v = 1;
    nlev = n;
    mac_base = (base_r + mem - macs) & am;
    cstart = (base_r + mem - macs - ctrs) & am;
    for (int i = 0; i <= MAXLV; i++) lvl_start[i] = 0;
    lvl_start[0] = (cstart - treesz) & am;
    sz = 64;
    for (int i = 1; i < n; i++) begin
      lvl_start[i] = (lvl_start[i-1] + sz) & am;
      sz = (i == 1) ? sz * roots : sz * arity_v;
    end
    lvl_start[n] = cstart;
  endfunction

  function automatic int sext3(logic [47:0] v);
    return v[2] ? int'(v[2:0]) - 8 : int'(v[2:0]);
  endfunction

  function automatic void predict_walk(addr_t a);
    logic [63:0] num, e;
    int unsigned lv;
    meta_rec_t r;
    num = ((a - base_r) & 48'hFFFF_FFFF_FFFF) / 64;
    num &= (64'd1 << 42) - 1;
    r.kind = KIND_MAC; r.level = 0; r.entry = num[41:0];
    r.addr = 48'(mac_base + num * 8); r.last = oop_r;
    expected_meta.push_back(r);
    if (oop_r) return;
    e = num; lv = nlev;
    r.kind = KIND_CTR; r.level = 4'(lv); r.entry = e[41:0];
    r.addr = 48'(lvl_start[lv] + pow2_scale(e, ctr_sh)); r.last = (lv == 0);
    expected_meta.push_back(r);
    while (lv > 0) begin
      if (lv == nlev) e = e >> leaf_sh;
      else e = e / arity_v;
      e &= (64'd1 << 42) - 1;
      lv--;
      r.kind = KIND_TREE; r.level = 4'(lv); r.entry = e[41:0];
      r.addr = 48'(lvl_start[lv] + pow2_scale(e, tree_sh)); r.last = (lv == 0);
      expected_meta.push_back(r);
    end
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_walk(data_address);
        void'(pending_addrs.pop_front());
      end
      if (src_gap > 0) src_gap <= src_gap - 1;
      if ((!in_valid || in_ready)) begin
        if (src_gap == 0 && !quiet_phase && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(1, 5);
          in_valid <= 1'b0;
        end else if (src_gap <= 1 && pending_addrs.size() > 0) begin
          in_valid <= 1'b1;
          data_address <= pending_addrs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int sink_gap = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        meta_rec_t w;
        if (expected_meta.size() == 0) begin
          $error("unexpected result kind=%0d addr=%h", kind, meta_address);
          errors++;
        end else begin
          w = expected_meta.pop_front();
          if (kind !== w.kind) begin
            $error("kind exp %0d got %0d", w.kind, kind); errors++;
          end
          if (tree_level !== w.level) begin
            $error("tree_level exp %0d got %0d", w.level, tree_level); errors++;
          end
          if (entry_number !== w.entry) begin
            $error("entry_number exp %h got %h", w.entry, entry_number); errors++;
          end
          if (meta_address !== w.addr) begin
            $error("meta_address exp %h got %h", w.addr, meta_address); errors++;
          end
          if (last !== w.last) begin
            $error("last exp %0d got %0d", w.last, last); errors++;
          end
        end
      end
      // one long hold, counted here, while the source keeps offering items
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (hold_sink && !hold_done) begin
        hold_cnt <= 200;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
        sink_gap <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE: base_r = val;
      REG_LINES: lines_r = val[42:0];
      REG_CTR_SHIFT: ctr_sh = sext3(val);
      REG_LEAF_SHIFT: leaf_sh = val[3:0];
      REG_TREE_SHIFT: tree_sh = sext3(val);
      REG_OOP: oop_r = val[0];
      default: ;
    endcase
    compute_layout();
  endtask

  task automatic drain();
    wait (pending_addrs.size() == 0 && !in_valid);
    wait (expected_meta.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(logic [47:0] b, logic [42:0] ln, int cs, int ls, int ts, bit o);
    write_reg(REG_BASE, b);
    write_reg(REG_LINES, 48'(ln));
    write_reg(REG_CTR_SHIFT, 48'(cs & 7));
    write_reg(REG_LEAF_SHIFT, 48'(ls));
    write_reg(REG_TREE_SHIFT, 48'(ts & 7));
    write_reg(REG_OOP, 48'(o));
  endtask

  function automatic addr_t region_addr();
    addr_t a;
    logic [63:0] span;
    span = lines_r * 64;
    if ($urandom_range(0, 9) == 0 || span == 0)
      a = 48'({$urandom, $urandom});
    else
      a = 48'(base_r + ({$urandom, $urandom} % span));
    return a;
  endfunction

  initial begin
    base_r = 0; lines_r = 0; ctr_sh = 0; leaf_sh = 6; tree_sh = 0; oop_r = 0;
    compute_layout();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // defaults: empty region
    pending_addrs.push_back(48'h0);
    pending_addrs.push_back(48'hFFFF_FFFF_FFFF);
    drain();

    // typical in-place layout, directed extremes
    setup(48'h1000_0000, 43'h10_0000, 0, 6, 0, 0);
    pending_addrs.push_back(48'h1000_0000);
    pending_addrs.push_back(48'h1000_0000 + 48'h10_0000 * 64 - 1);
    pending_addrs.push_back(48'h0);
    pending_addrs.push_back(48'hFFFF_FFFF_FFFF);
    pending_addrs.push_back(48'hAAAA_AAAA_AAAA);
    pending_addrs.push_back(48'h5555_5555_5555);
    drain();
    // write to an unused index is ignored
    write_reg(3'd7, 48'h3);
    write_reg(3'd6, 48'hFFFF);
    // deep tree, saturated level count, negative extremes
    setup(48'hFFFF_FFFF_FFFF, 43'h7FF_FFFF_FFFF, 3, 15, -4, 0);
    pending_addrs.push_back(48'h0);
    pending_addrs.push_back(48'hFFFF_FFFF_FFC0);
    drain();
    setup(48'h0, 43'h400_0000_0000, -4, 3, 3, 0);
    pending_addrs.push_back(48'h1234_5678_9ABC);
    pending_addrs.push_back(48'hFFFF_FFFF_FFFF);
    drain();
    // tiny region: no tree levels
    setup(48'h4000, 43'd8, -3, 9, -3, 0);
    pending_addrs.push_back(48'h4000);
    pending_addrs.push_back(48'h41C0);
    drain();
    // out-of-place
    setup(48'h8000_0000, 43'h100_0000, 0, 0, 0, 1);
    pending_addrs.push_back(48'h8000_0000);
    pending_addrs.push_back(48'h7FFF_FFFF);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      logic [42:0] ln;
      case ($urandom_range(0, 3))
        0: ln = 43'($urandom_range(0, 4096));
        1: ln = 43'({$urandom, $urandom});
        2: ln = 43'(1) << $urandom_range(0, 42);
        default: ln = 43'($urandom);
      endcase
      setup({$urandom, $urandom}, ln, $urandom_range(0, 7) - 4, $urandom_range(0, 15),
            $urandom_range(0, 7) - 4, ($urandom_range(0, 4) == 0));
      if (ph == 6) quiet_phase = 1;
      for (int i = 0; i < 30; i++) pending_addrs.push_back(region_addr());
      if (ph == 2) hold_sink = 1;
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0 && expected_meta.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
